>>> src/mvna_pkg.sv
// Shared types, constants and helpers for the mesh vertex normal accumulator.
// No dependencies.
package mvna_pkg;

    localparam int VERTICES   = 4096;
    localparam int ADDR_W     = $clog2(VERTICES);
    localparam int COUNT_BITS = 8;
    localparam int POS_W      = 24;
    localparam int SUM_W      = 24;
    localparam int NORM_W     = 16;
    localparam int DIFF_W     = POS_W + 1;
    localparam int CROSS_W    = 2 * DIFF_W + 1;
    localparam int MUL_W      = 32;
    localparam int SQ_W       = 62;
    localparam int ROOT_W     = 31;
    localparam int DNUM_W     = 25;
    localparam int ONE_Q14    = 16384;

    localparam logic [1:0] ACT_LOAD = 2'd0;
    localparam logic [1:0] ACT_TRI  = 2'd1;
    localparam logic [1:0] ACT_READ = 2'd2;
    localparam logic [1:0] ACT_NONE = 2'd3;

    typedef logic signed [POS_W-1:0]   pos_t;
    typedef logic signed [SUM_W-1:0]   sum_t;
    typedef logic signed [NORM_W-1:0]  norm_t;
    typedef logic [COUNT_BITS-1:0]     count_t;
    typedef logic signed [DIFF_W-1:0]  diff_t;
    typedef logic signed [CROSS_W-1:0] cross_t;
    typedef logic [CROSS_W-1:0]        mag_t;

    typedef struct packed {
        pos_t x;
        pos_t y;
        pos_t z;
    } pos_vec_t;

    typedef struct packed {
        sum_t   x;
        sum_t   y;
        sum_t   z;
        count_t cnt;
    } acc_t;

    function automatic sum_t sat_add(sum_t s, norm_t n);
        logic signed [SUM_W:0] t;
        t = (SUM_W+1)'(s) + (SUM_W+1)'(n);
        if (t[SUM_W] != t[SUM_W-1])
            return t[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
        return t[SUM_W-1:0];
    endfunction

endpackage

>>> src/mesh_vertex_normal_accumulator.sv
// Mesh vertex normal accumulator: vertex table, face normals, averaged normals.
// Depends on mvna_pkg and mvna_ram (position table and sum/count table).
// Triangle: normalise shift, 31-step square root and three 15-step divisions, skipped when
// degenerate; read: three 25-step divisions, skipped on zero count. Load and unused action
// go straight to the response.
// One transaction in flight; the next request is accepted once rsp_valid has risen, even under stall.
// Reset clears control only; table contents are undefined until loaded.
module mesh_vertex_normal_accumulator
    import mvna_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_stall,
    input  logic [1:0]        action,
    input  logic [ADDR_W-1:0] corner_a,
    input  logic [ADDR_W-1:0] corner_b,
    input  logic [ADDR_W-1:0] corner_c,
    input  pos_t              pos_x,
    input  pos_t              pos_y,
    input  pos_t              pos_z,
    output logic              rsp_valid,
    input  logic              rsp_stall,
    output norm_t             norm_x,
    output norm_t             norm_y,
    output norm_t             norm_z,
    output logic              degenerate
);

    localparam logic [4:0] S_IDLE = 5'd0;
    localparam logic [4:0] S_PRD  = 5'd1;
    localparam logic [4:0] S_PWT  = 5'd2;
    localparam logic [4:0] S_DIFF = 5'd3;
    localparam logic [4:0] S_MUL  = 5'd4;
    localparam logic [4:0] S_MAG  = 5'd5;
    localparam logic [4:0] S_NORM = 5'd6;
    localparam logic [4:0] S_SQ   = 5'd7;
    localparam logic [4:0] S_SQRT = 5'd8;
    localparam logic [4:0] S_DSET = 5'd9;
    localparam logic [4:0] S_DRUN = 5'd10;
    localparam logic [4:0] S_DFIN = 5'd11;
    localparam logic [4:0] S_ARD  = 5'd12;
    localparam logic [4:0] S_AWT  = 5'd13;
    localparam logic [4:0] S_RRD  = 5'd14;
    localparam logic [4:0] S_RWT  = 5'd15;
    localparam logic [4:0] S_DONE = 5'd16;

    logic [4:0]              state_reg, state_next;
    logic                    rsp_valid_reg, rsp_valid_next;
    logic [1:0]              act_reg, act_next;
    logic [ADDR_W-1:0]       corner_reg [3];
    logic [ADDR_W-1:0]       corner_next [3];
    logic [1:0]              k_reg, k_next;
    logic [4:0]              step_reg, step_next;
    logic [4:0]              dlen_reg, dlen_next;
    pos_vec_t                p_reg [3];
    pos_vec_t                p_next [3];
    diff_t                   u_reg [3];
    diff_t                   u_next [3];
    diff_t                   v_reg [3];
    diff_t                   v_next [3];
    logic signed [2*MUL_W-1:0] prod_reg, prod_next;
    cross_t                  cr_reg [3];
    cross_t                  cr_next [3];
    mag_t                    m_reg [3];
    mag_t                    m_next [3];
    mag_t                    mx_reg, mx_next;
    logic [SQ_W-1:0]         sq_reg, sq_next;
    logic [ROOT_W:0]         srem_reg, srem_next;
    logic [ROOT_W-1:0]       root_reg, root_next;
    logic [ROOT_W:0]         drem_reg, drem_next;
    logic [DNUM_W-1:0]       dnum_reg, dnum_next;
    logic [DNUM_W-1:0]       dq_reg, dq_next;
    logic [ROOT_W:0]         dd_reg, dd_next;
    sum_t                    s_reg [3];
    sum_t                    s_next [3];
    count_t                  cnt_reg, cnt_next;
    norm_t                   n_reg [3];
    norm_t                   n_next [3];
    logic                    degen_reg, degen_next;
    norm_t                   out_reg [3];
    norm_t                   out_next [3];
    logic                    odeg_reg, odeg_next;

    logic                    pos_we;
    pos_vec_t                pos_wdata;
    pos_vec_t                pos_rdata;
    logic                    acc_we;
    acc_t                    acc_wdata;
    acc_t                    acc_rdata;
    logic [ADDR_W-1:0]       ram_addr;
    logic signed [MUL_W-1:0] mul_a;
    logic signed [MUL_W-1:0] mul_b;

    assign req_stall = (state_reg != S_IDLE);
    assign ram_addr  = (state_reg == S_IDLE) ? corner_a : corner_reg[k_reg];

    mvna_ram #(.WIDTH($bits(pos_vec_t)), .DEPTH(VERTICES)) u_pos_ram (
        .clk   (clk),
        .we    (pos_we),
        .addr  (ram_addr),
        .wdata (pos_wdata),
        .rdata (pos_rdata)
    );

    mvna_ram #(.WIDTH($bits(acc_t)), .DEPTH(VERTICES)) u_acc_ram (
        .clk   (clk),
        .we    (acc_we),
        .addr  (ram_addr),
        .wdata (acc_wdata),
        .rdata (acc_rdata)
    );

    always_comb
    begin
        logic [2:0]          jm;
        mag_t                mg [3];
        mag_t                mxv;
        logic [SQ_W-1:0]     sq_add;
        logic [ROOT_W+2:0]   st;
        logic [ROOT_W+2:0]   strial;
        logic [ROOT_W+1:0]   dt;
        logic [44:0]         numer;
        logic [DNUM_W-1:0]   rnum;
        logic [DNUM_W-1:0]   q;
        logic                neg;
        sum_t                sv;
        logic                ge;

        state_next     = state_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        act_next       = act_reg;
        corner_next    = corner_reg;
        k_next         = k_reg;
        step_next      = step_reg;
        dlen_next      = dlen_reg;
        p_next         = p_reg;
        u_next         = u_reg;
        v_next         = v_reg;
        prod_next      = prod_reg;
        cr_next        = cr_reg;
        m_next         = m_reg;
        mx_next        = mx_reg;
        sq_next        = sq_reg;
        srem_next      = srem_reg;
        root_next      = root_reg;
        drem_next      = drem_reg;
        dnum_next      = dnum_reg;
        dq_next        = dq_reg;
        dd_next        = dd_reg;
        s_next         = s_reg;
        cnt_next       = cnt_reg;
        n_next         = n_reg;
        degen_next     = degen_reg;
        out_next       = out_reg;
        odeg_next      = odeg_reg;
        pos_we         = 1'b0;
        pos_wdata      = '{x: pos_x, y: pos_y, z: pos_z};
        acc_we         = 1'b0;
        acc_wdata      = '0;
        mul_a          = '0;
        mul_b          = '0;
        jm             = step_reg[2:0] - 3'd1;
        mg             = m_reg;
        mxv            = '0;
        sq_add         = '0;
        st             = '0;
        strial         = '0;
        dt             = '0;
        numer          = '0;
        rnum           = '0;
        q              = '0;
        neg            = 1'b0;
        sv             = '0;
        ge             = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    act_next    = action;
                    corner_next = '{corner_a, corner_b, corner_c};
                    k_next      = '0;
                    n_next      = '{default: '0};
                    degen_next  = 1'b0;
                    unique case (action)
                        ACT_LOAD:
                        begin
                            pos_we     = 1'b1;
                            acc_we     = 1'b1;
                            state_next = S_DONE;
                        end
                        ACT_TRI:  state_next = S_PRD;
                        ACT_READ: state_next = S_RRD;
                        ACT_NONE: state_next = S_DONE;
                        default:  state_next = S_DONE;
                    endcase
                end
            end
            S_PRD:
            begin
                state_next = S_PWT;
            end
            S_PWT:
            begin
                p_next[k_reg] = pos_rdata;
                if (k_reg == 2'd2)
                begin
                    state_next = S_DIFF;
                end
                else
                begin
                    k_next     = k_reg + 2'd1;
                    state_next = S_PRD;
                end
            end
            S_DIFF:
            begin
                u_next[0] = DIFF_W'(p_reg[2].x) - DIFF_W'(p_reg[0].x);
                u_next[1] = DIFF_W'(p_reg[2].y) - DIFF_W'(p_reg[0].y);
                u_next[2] = DIFF_W'(p_reg[2].z) - DIFF_W'(p_reg[0].z);
                v_next[0] = DIFF_W'(p_reg[1].x) - DIFF_W'(p_reg[2].x);
                v_next[1] = DIFF_W'(p_reg[1].y) - DIFF_W'(p_reg[2].y);
                v_next[2] = DIFF_W'(p_reg[1].z) - DIFF_W'(p_reg[2].z);
                step_next = '0;
                state_next = S_MUL;
            end
            S_MUL:
            begin
                unique case (step_reg[2:0])
                    3'd0:    begin mul_a = MUL_W'(u_reg[1]); mul_b = MUL_W'(v_reg[2]); end
                    3'd1:    begin mul_a = MUL_W'(u_reg[2]); mul_b = MUL_W'(v_reg[1]); end
                    3'd2:    begin mul_a = MUL_W'(u_reg[2]); mul_b = MUL_W'(v_reg[0]); end
                    3'd3:    begin mul_a = MUL_W'(u_reg[0]); mul_b = MUL_W'(v_reg[2]); end
                    3'd4:    begin mul_a = MUL_W'(u_reg[0]); mul_b = MUL_W'(v_reg[1]); end
                    3'd5:    begin mul_a = MUL_W'(u_reg[1]); mul_b = MUL_W'(v_reg[0]); end
                    default: begin mul_a = '0; mul_b = '0; end
                endcase
                prod_next = mul_a * mul_b;
                if (step_reg != '0)
                begin
                    if (!jm[0])
                        cr_next[jm[2:1]] = CROSS_W'(prod_reg);
                    else
                        cr_next[jm[2:1]] = cr_reg[jm[2:1]] - CROSS_W'(prod_reg);
                end
                if (step_reg == 5'd6)
                    state_next = S_MAG;
                else
                    step_next = step_reg + 5'd1;
            end
            S_MAG:
            begin
                for (int i = 0; i < 3; i++)
                    mg[i] = cr_reg[i][CROSS_W-1] ? mag_t'(-cr_reg[i]) : mag_t'(cr_reg[i]);
                mxv = mg[0];
                if (mg[1] > mxv) mxv = mg[1];
                if (mg[2] > mxv) mxv = mg[2];
                m_next  = mg;
                mx_next = mxv;
                if (mxv == '0)
                begin
                    degen_next = 1'b1;
                    k_next     = '0;
                    state_next = S_ARD;
                end
                else
                begin
                    state_next = S_NORM;
                end
            end
            S_NORM:
            begin
                if (|mx_reg[CROSS_W-1:30])
                begin
                    mx_next = mx_reg >> 1;
                    for (int i = 0; i < 3; i++)
                        m_next[i] = m_reg[i] >> 1;
                end
                else if (!mx_reg[29])
                begin
                    mx_next = mx_reg << 1;
                    for (int i = 0; i < 3; i++)
                        m_next[i] = m_reg[i] << 1;
                end
                else
                begin
                    step_next  = '0;
                    sq_next    = '0;
                    state_next = S_SQ;
                end
            end
            S_SQ:
            begin
                unique case (step_reg[1:0])
                    2'd0:    mul_a = signed'({2'b00, m_reg[0][29:0]});
                    2'd1:    mul_a = signed'({2'b00, m_reg[1][29:0]});
                    2'd2:    mul_a = signed'({2'b00, m_reg[2][29:0]});
                    default: mul_a = '0;
                endcase
                mul_b     = mul_a;
                prod_next = mul_a * mul_b;
                sq_add    = SQ_W'(prod_reg);
                if (step_reg != '0)
                    sq_next = sq_reg + sq_add;
                if (step_reg == 5'd3)
                begin
                    step_next  = '0;
                    srem_next  = '0;
                    root_next  = '0;
                    state_next = S_SQRT;
                end
                else
                begin
                    step_next = step_reg + 5'd1;
                end
            end
            S_SQRT:
            begin
                st        = {srem_reg, sq_reg[SQ_W-1:SQ_W-2]};
                strial    = {1'b0, root_reg, 2'b01};
                ge        = (st >= strial);
                srem_next = ge ? (ROOT_W+1)'(st - strial) : (ROOT_W+1)'(st);
                root_next = {root_reg[ROOT_W-2:0], ge};
                sq_next   = sq_reg << 2;
                if (step_reg == 5'(ROOT_W - 1))
                begin
                    k_next     = '0;
                    state_next = S_DSET;
                end
                else
                begin
                    step_next = step_reg + 5'd1;
                end
            end
            S_DSET:
            begin
                dq_next   = '0;
                step_next = '0;
                if (act_reg == ACT_TRI)
                begin
                    numer     = {m_reg[k_reg][29:0], 14'b0} + 45'(root_reg >> 1);
                    drem_next = (ROOT_W+1)'(numer[44:15]);
                    dnum_next = {numer[14:0], 10'b0};
                    dd_next   = {1'b0, root_reg};
                    dlen_next = 5'd14;
                end
                else
                begin
                    sv        = s_reg[k_reg];
                    rnum      = sv[SUM_W-1] ? DNUM_W'(-DNUM_W'(sv)) : DNUM_W'(sv);
                    dnum_next = rnum + DNUM_W'(cnt_reg >> 1);
                    drem_next = '0;
                    dd_next   = (ROOT_W+1)'(cnt_reg);
                    dlen_next = 5'(DNUM_W - 1);
                end
                state_next = S_DRUN;
            end
            S_DRUN:
            begin
                dt        = {drem_reg, dnum_reg[DNUM_W-1]};
                ge        = (dt >= {1'b0, dd_reg});
                drem_next = ge ? (ROOT_W+1)'(dt - {1'b0, dd_reg}) : (ROOT_W+1)'(dt);
                dq_next   = {dq_reg[DNUM_W-2:0], ge};
                dnum_next = dnum_reg << 1;
                if (step_reg == dlen_reg)
                    state_next = S_DFIN;
                else
                    step_next = step_reg + 5'd1;
            end
            S_DFIN:
            begin
                q   = (dq_reg > DNUM_W'(ONE_Q14)) ? DNUM_W'(ONE_Q14) : dq_reg;
                sv  = s_reg[k_reg];
                neg = (act_reg == ACT_TRI) ? cr_reg[k_reg][CROSS_W-1] : sv[SUM_W-1];
                n_next[k_reg] = neg ? -NORM_W'(q) : NORM_W'(q);
                if (k_reg == 2'd2)
                begin
                    k_next     = '0;
                    state_next = (act_reg == ACT_TRI) ? S_ARD : S_DONE;
                end
                else
                begin
                    k_next     = k_reg + 2'd1;
                    state_next = S_DSET;
                end
            end
            S_ARD:
            begin
                state_next = S_AWT;
            end
            S_AWT:
            begin
                acc_we          = 1'b1;
                acc_wdata.x     = sat_add(acc_rdata.x, n_reg[0]);
                acc_wdata.y     = sat_add(acc_rdata.y, n_reg[1]);
                acc_wdata.z     = sat_add(acc_rdata.z, n_reg[2]);
                acc_wdata.cnt   = (acc_rdata.cnt == '1) ? acc_rdata.cnt
                                                        : acc_rdata.cnt + count_t'(1);
                if (k_reg == 2'd2)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    k_next     = k_reg + 2'd1;
                    state_next = S_ARD;
                end
            end
            S_RRD:
            begin
                state_next = S_RWT;
            end
            S_RWT:
            begin
                s_next   = '{acc_rdata.x, acc_rdata.y, acc_rdata.z};
                cnt_next = acc_rdata.cnt;
                if (acc_rdata.cnt == '0)
                begin
                    degen_next = 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    k_next     = '0;
                    state_next = S_DSET;
                end
            end
            S_DONE:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    out_next       = n_reg;
                    odeg_next      = degen_reg;
                    rsp_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg    <= act_next;
        corner_reg <= corner_next;
        k_reg      <= k_next;
        step_reg   <= step_next;
        dlen_reg   <= dlen_next;
        p_reg      <= p_next;
        u_reg      <= u_next;
        v_reg      <= v_next;
        prod_reg   <= prod_next;
        cr_reg     <= cr_next;
        m_reg      <= m_next;
        mx_reg     <= mx_next;
        sq_reg     <= sq_next;
        srem_reg   <= srem_next;
        root_reg   <= root_next;
        drem_reg   <= drem_next;
        dnum_reg   <= dnum_next;
        dq_reg     <= dq_next;
        dd_reg     <= dd_next;
        s_reg      <= s_next;
        cnt_reg    <= cnt_next;
        n_reg      <= n_next;
        degen_reg  <= degen_next;
        out_reg    <= out_next;
        odeg_reg   <= odeg_next;
    end

    assign rsp_valid  = rsp_valid_reg;
    assign norm_x     = out_reg[0];
    assign norm_y     = out_reg[1];
    assign norm_z     = out_reg[2];
    assign degenerate = odeg_reg;

endmodule

>>> src/mvna_ram.sv
// Generic single-port RAM with registered read data.
// No dependencies.
module mvna_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

>>> tb/mesh_vertex_normal_accumulator_tb.sv
// Testbench for mesh_vertex_normal_accumulator: a directed table, then random load/triangle/
// read/none traffic and saturation runs, checked against a behavioural predictor.
// Depends on mvna_pkg and the block under test.
module mesh_vertex_normal_accumulator_tb
    import mvna_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        norm_t x;
        norm_t y;
        norm_t z;
        logic  d;
    } normal_res_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              req_valid = 1'b0;
    logic              req_stall;
    logic [1:0]        action = ACT_LOAD;
    logic [ADDR_W-1:0] corner_a = '0;
    logic [ADDR_W-1:0] corner_b = '0;
    logic [ADDR_W-1:0] corner_c = '0;
    pos_t              pos_x = '0;
    pos_t              pos_y = '0;
    pos_t              pos_z = '0;
    logic              rsp_valid;
    logic              rsp_stall = 1'b0;
    norm_t             norm_x;
    norm_t             norm_y;
    norm_t             norm_z;
    logic              degenerate;

    mesh_vertex_normal_accumulator dut (.*);

    // predictor state
    longint      vx [VERTICES];
    longint      vy [VERTICES];
    longint      vz [VERTICES];
    longint      acc_x [VERTICES];
    longint      acc_y [VERTICES];
    longint      acc_z [VERTICES];
    int          faces [VERTICES];
    bit          loaded [VERTICES];
    int          live_idx[$];

    normal_res_t pending_normals[$];
    int          errors = 0;
    bit          idle_on = 1'b0;
    int          hold_req = 0;

    initial begin
        forever #5 clk = ~clk;
    end

    initial begin
        #60ms;
        $display("FAILURE");
        $finish;
    end

    function automatic longint unsigned root64(longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic longint sum_sat(longint s, longint n);
        longint t;
        t = s + n;
        if (t > 8388607) return 8388607;
        if (t < -8388608) return -8388608;
        return t;
    endfunction

    function automatic norm_t mean_of(longint s, int cnt);
        longint q;
        q = ((s < 0 ? -s : s) + cnt / 2) / cnt;
        if (q > ONE_Q14) q = ONE_Q14;
        return norm_t'(s < 0 ? -q : q);
    endfunction

    function automatic void add_face(int i, longint n[3]);
        acc_x[i] = sum_sat(acc_x[i], n[0]);
        acc_y[i] = sum_sat(acc_y[i], n[1]);
        acc_z[i] = sum_sat(acc_z[i], n[2]);
        if (faces[i] < (1 << COUNT_BITS) - 1) faces[i]++;
    endfunction

    function automatic normal_res_t predict_normal(logic [1:0] act, int a, int b, int c,
                                                   pos_t px, pos_t py, pos_t pz);
        normal_res_t     r;
        longint          u[3], v[3], cr[3], n[3];
        longint unsigned m[3], mx, len, q;
        r = '{0, 0, 0, 1'b0};
        n = '{0, 0, 0};
        if (act == ACT_LOAD) begin
            vx[a] = px; vy[a] = py; vz[a] = pz;
            acc_x[a] = 0; acc_y[a] = 0; acc_z[a] = 0;
            faces[a] = 0;
            if (!loaded[a]) live_idx.insert(live_idx.size(), a);
            loaded[a] = 1'b1;
        end else if (act == ACT_TRI) begin
            u[0] = vx[c] - vx[a]; u[1] = vy[c] - vy[a]; u[2] = vz[c] - vz[a];
            v[0] = vx[b] - vx[c]; v[1] = vy[b] - vy[c]; v[2] = vz[b] - vz[c];
            cr[0] = u[1] * v[2] - u[2] * v[1];
            cr[1] = u[2] * v[0] - u[0] * v[2];
            cr[2] = u[0] * v[1] - u[1] * v[0];
            for (int k = 0; k < 3; k++) m[k] = cr[k] < 0 ? -cr[k] : cr[k];
            mx = m[0];
            if (m[1] > mx) mx = m[1];
            if (m[2] > mx) mx = m[2];
            if (mx == 0) begin
                r.d = 1'b1;
            end else begin
                while (mx >= (64'd1 << 30)) begin
                    mx >>= 1;
                    for (int k = 0; k < 3; k++) m[k] >>= 1;
                end
                while (mx < (64'd1 << 29)) begin
                    mx <<= 1;
                    for (int k = 0; k < 3; k++) m[k] <<= 1;
                end
                len = root64(m[0] * m[0] + m[1] * m[1] + m[2] * m[2]);
                for (int k = 0; k < 3; k++) begin
                    q = (m[k] * ONE_Q14 + len / 2) / len;
                    if (q > ONE_Q14) q = ONE_Q14;
                    n[k] = cr[k] < 0 ? -longint'(q) : longint'(q);
                end
                r.x = norm_t'(n[0]); r.y = norm_t'(n[1]); r.z = norm_t'(n[2]);
            end
            add_face(a, n);
            add_face(b, n);
            add_face(c, n);
        end else if (act == ACT_READ) begin
            if (faces[a] == 0) begin
                r.d = 1'b1;
            end else begin
                r.x = mean_of(acc_x[a], faces[a]);
                r.y = mean_of(acc_y[a], faces[a]);
                r.z = mean_of(acc_z[a], faces[a]);
            end
        end
        return r;
    endfunction

    // drives one transaction; typed expectation replaces the prediction when given
    task automatic send(logic [1:0] act, int a, int b, int c, pos_t px, pos_t py, pos_t pz,
                        bit typed = 1'b0, normal_res_t want = '{0, 0, 0, 1'b0});
        normal_res_t r;
        while (idle_on && $urandom_range(99) < 37) begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        action    <= act;
        corner_a  <= a[ADDR_W-1:0];
        corner_b  <= b[ADDR_W-1:0];
        corner_c  <= c[ADDR_W-1:0];
        pos_x     <= px;
        pos_y     <= py;
        pos_z     <= pz;
        @(posedge clk);
        while (req_stall) @(posedge clk);
        r = predict_normal(act, a, b, c, px, py, pz);
        if (typed) r = want;
        pending_normals.insert(pending_normals.size(), r);
    endtask

    function automatic pos_t rand_pos();
        if ($urandom_range(3) == 0) return pos_t'($urandom);
        return pos_t'(int'($urandom_range(131071)) - 65536);
    endfunction

    function automatic int pick_live();
        return live_idx[$urandom_range(live_idx.size() - 1)];
    endfunction

    task automatic random_item();
        int   sel, a, b, c;
        sel = $urandom_range(99);
        a = pick_live();
        b = pick_live();
        c = pick_live();
        if (sel < 18) begin
            a = $urandom_range(1) ? $urandom_range(31) : $urandom_range(VERTICES - 1);
            send(ACT_LOAD, a, $urandom, $urandom, rand_pos(), rand_pos(), rand_pos());
        end else if (sel < 63) begin
            send(ACT_TRI, a, b, c, rand_pos(), rand_pos(), rand_pos());
        end else if (sel < 68) begin
            send(ACT_TRI, a, a, c, rand_pos(), rand_pos(), rand_pos());
        end else if (sel < 94) begin
            send(ACT_READ, a, $urandom, $urandom, rand_pos(), rand_pos(), rand_pos());
        end else begin
            send(ACT_NONE, $urandom, $urandom, $urandom, rand_pos(), rand_pos(), rand_pos());
        end
    endtask

    // receiver
    always @(posedge clk) begin
        if (hold_req > 0) begin
            rsp_stall <= 1'b1;
            hold_req  <= hold_req - 1;
        end else begin
            rsp_stall <= idle_on && ($urandom_range(99) < 37);
        end
    end

    always @(posedge clk) begin
        normal_res_t e;
        if (rsp_valid && !rsp_stall) begin
            if (pending_normals.size() == 0) begin
                $display("%0t: unexpected transaction x=%0d y=%0d z=%0d d=%0b", $time,
                         norm_x, norm_y, norm_z, degenerate);
                errors++;
            end else begin
                e = pending_normals.pop_front();
                if (norm_x !== e.x) begin
                    $display("%0t: norm_x expected %0d actual %0d", $time, e.x, norm_x);
                    errors++;
                end
                if (norm_y !== e.y) begin
                    $display("%0t: norm_y expected %0d actual %0d", $time, e.y, norm_y);
                    errors++;
                end
                if (norm_z !== e.z) begin
                    $display("%0t: norm_z expected %0d actual %0d", $time, e.z, norm_z);
                    errors++;
                end
                if (degenerate !== e.d) begin
                    $display("%0t: degenerate expected %0b actual %0b", $time, e.d,
                             degenerate);
                    errors++;
                end
            end
        end
    end

    initial begin
        pos_t pmax, pmin;
        pmax = 24'sh7FFFFF;
        pmin = 24'sh800000;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        send(ACT_LOAD, 0, 4095, 4095, 0, 0, 0, 1, '{0, 0, 0, 0});
        send(ACT_LOAD, 4095, 0, 0, pmax, pmax, pmax, 1, '{0, 0, 0, 0});
        send(ACT_LOAD, 1, 0, 0, 4096, 0, 0, 1, '{0, 0, 0, 0});
        send(ACT_LOAD, 2, 0, 0, 0, 4096, 0, 1, '{0, 0, 0, 0});
        send(ACT_READ, 0, 0, 0, 0, 0, 0, 1, '{0, 0, 0, 1});
        send(ACT_TRI, 0, 1, 2, 0, 0, 0, 1, '{0, 0, -16384, 0});
        send(ACT_TRI, 0, 0, 0, 0, 0, 0, 1, '{0, 0, 0, 1});
        send(ACT_READ, 0, 0, 0, 0, 0, 0, 1, '{0, 0, -4096, 0});
        send(ACT_NONE, 4095, 4095, 4095, pmin, pmax, -1, 1, '{0, 0, 0, 0});
        send(ACT_LOAD, 4094, 4095, 4095, pmin, pmin, pmin, 1, '{0, 0, 0, 0});
        send(ACT_TRI, 4094, 4095, 0, 0, 0, 0);
        send(ACT_LOAD, 3, 0, 0, pmin, pmax, 0, 1, '{0, 0, 0, 0});
        send(ACT_TRI, 4094, 4095, 3, 0, 0, 0);
        send(ACT_TRI, 3, 1, 4095, 0, 0, 0);
        send(ACT_READ, 4095, 0, 0, 0, 0, 0);
        send(ACT_READ, 4094, 0, 0, 0, 0, 0);
        send(ACT_READ, 1, 0, 0, 0, 0, 0);
        send(ACT_READ, 3, 4095, 4095, pmax, pmin, pmax);

        // long stretch without idling, then random idling
        for (int i = 0; i < 200; i++) random_item();
        idle_on = 1'b1;
        for (int i = 0; i < 400; i++) begin
            if (i == 100) hold_req = 400;
            if (i == 250) begin
                req_valid <= 1'b0;
                wait (pending_normals.size() == 0);
                @(posedge clk);
            end
            random_item();
        end

        // saturate sums and counts in both directions
        send(ACT_LOAD, 100, 0, 0, 0, 0, 0);
        send(ACT_LOAD, 101, 0, 0, 4096, 0, 0);
        send(ACT_LOAD, 102, 0, 0, 0, 4096, 0);
        for (int i = 0; i < 520; i++) send(ACT_TRI, 100, 101, 102, rand_pos(), 0, 0);
        send(ACT_READ, 100, 0, 0, 0, 0, 0);
        send(ACT_LOAD, 100, 0, 0, 0, 0, 0);
        send(ACT_LOAD, 101, 0, 0, 4096, 0, 0);
        for (int i = 0; i < 520; i++) send(ACT_TRI, 100, 102, 101, 0, rand_pos(), 0);
        send(ACT_READ, 100, 0, 0, 0, 0, 0);
        send(ACT_READ, 102, 0, 0, 0, 0, 0);
        for (int i = 0; i < 100; i++) random_item();
        req_valid <= 1'b0;

        wait (pending_normals.size() == 0);
        repeat (300) @(posedge clk);
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
